// ===== rtl/extended_gcd_unit_core_macros.svh =====
// Assertion macros shared by the extended gcd RTL.
`ifndef EXTENDED_GCD_UNIT_CORE_MACROS_SVH
`define EXTENDED_GCD_UNIT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define EGCD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("extended gcd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EGCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("extended gcd assertion failed");

`else

`define EGCD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define EGCD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/egcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

    // Rounds a bit count up to a whole number of bytes.
    function automatic int pad_to_bytes(input int bits);
        return ((bits + 7) >> 3) << 3;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/extended_gcd_unit_core.sv =====
// Each Euclid division step runs CHECK, DIV and UPDATE; one operand pair is worked at a time,
// and a new pair is taken only once the last result is in the output register.
// Each step runs a restoring divider one quotient bit per cycle, with the coefficient
// products built bit-serially in the same cycles.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

`include "extended_gcd_unit_core_macros.svh"

module extended_gcd_unit_core
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // operand_a, operand_b (lowest bits first)
    input  wire logic [pad_to_bytes(2*DATA_WIDTH)-1:0]         s_tdata,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // divisor, coef_a, coef_b (lowest bits first)
    output logic [pad_to_bytes(3*DATA_WIDTH-1)-1:0]            m_tdata
);

    localparam int DW    = DATA_WIDTH;
    localparam int OUT_W = pad_to_bytes(3*DATA_WIDTH-1);
    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE
    } state_t;

    // The finish step is folded into CHECK; this extra state holds a result
    // while the output register is still occupied.
    typedef enum logic {
        FIN_NO,
        FIN_WAIT
    } fin_t;

    state_t              state_reg;
    fin_t                fin_reg;
    logic                m_tvalid_reg;
    logic [DW-2:0]       divisor_reg;
    logic [DW-1:0]       coef_a_reg;
    logic [DW-1:0]       coef_b_reg;

    logic [DW-1:0]       r0_reg, r1_reg;
    logic [DW-1:0]       p0_reg, q0_reg, p1_reg, q1_reg;
    logic [DW-1:0]       rem_reg, dvd_reg;
    logic [DW-1:0]       accp_reg, accq_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                neg_a_reg, neg_b_reg;

    logic [DW-1:0]       op_a, op_b, mag_a, mag_b;
    logic [DW+1:0]       trial;
    logic                qbit;
    logic [DW-1:0]       rem_next, accp_next, accq_next;
    logic                out_free;

    // Input unpacking and operand magnitudes.
    assign op_a  = s_tdata[DW-1:0];
    assign op_b  = s_tdata[2*DW-1:DW];
    assign mag_a = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[DW-1] ? (~op_b + 1'b1) : op_b;

    // One restoring division bit and the matching Horner step of quo*p1, quo*q1.
    assign trial     = {1'b0, rem_reg, dvd_reg[DW-1]} - {2'b00, r1_reg};
    assign qbit      = ~trial[DW+1];
    assign rem_next  = qbit ? trial[DW-1:0] : {rem_reg[DW-2:0], dvd_reg[DW-1]};
    assign accp_next = {accp_reg[DW-2:0], 1'b0} + (qbit ? p1_reg : '0);
    assign accq_next = {accq_reg[DW-2:0], 1'b0} + (qbit ? q1_reg : '0);

    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE) && (fin_reg == FIN_NO);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({coef_b_reg, coef_a_reg, divisor_reg});

    // Sequencer, datapath registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fin_reg      <= FIN_NO;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A pending result reloads the output register itself below.
            if (m_tvalid_reg && m_tready && (fin_reg == FIN_NO)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (fin_reg == FIN_WAIT) begin
                        // Result ready, waiting for the output register.
                        if (out_free) begin
                            divisor_reg  <= r0_reg[DW-2:0];
                            coef_a_reg   <= neg_a_reg ? (~p0_reg + 1'b1) : p0_reg;
                            coef_b_reg   <= neg_b_reg ? (~q0_reg + 1'b1) : q0_reg;
                            m_tvalid_reg <= 1'b1;
                            fin_reg      <= FIN_NO;
                        end
                    end else if (s_tvalid) begin
                        r0_reg    <= mag_a;
                        r1_reg    <= mag_b;
                        neg_a_reg <= op_a[DW-1];
                        neg_b_reg <= op_b[DW-1];
                        p0_reg    <= DW'(1);
                        q0_reg    <= '0;
                        p1_reg    <= '0;
                        q1_reg    <= DW'(1);
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK: begin
                    if (r1_reg == '0) begin
                        fin_reg   <= FIN_WAIT;
                        state_reg <= ST_IDLE;
                    end else begin
                        rem_reg   <= '0;
                        dvd_reg   <= r0_reg;
                        accp_reg  <= '0;
                        accq_reg  <= '0;
                        cnt_reg   <= CNT_W'(DW - 1);
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= {dvd_reg[DW-2:0], 1'b0};
                    accp_reg <= accp_next;
                    accq_reg <= accq_next;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_UPDATE;
                    end
                end

                ST_UPDATE: begin
                    // Shift the coefficient matrix and the remainder pair.
                    p0_reg    <= p1_reg;
                    q0_reg    <= q1_reg;
                    p1_reg    <= p0_reg - accp_reg;
                    q1_reg    <= q0_reg - accq_reg;
                    r0_reg    <= r1_reg;
                    r1_reg    <= rem_reg;
                    state_reg <= ST_CHECK;
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The partial remainder always stays below the divisor.
    `EGCD_ASSERT_IMPL(a_rem_below_divisor, aclk, aresetn,
        state_reg == ST_DIV, rem_reg < r1_reg)

    // Every Euclid step strictly shrinks the second remainder.
    `EGCD_ASSERT_NEXT(a_step_shrinks, aclk, aresetn,
        state_reg == ST_UPDATE, r1_reg < $past(r1_reg))

    // A finished result is held while the output register is occupied.
    `EGCD_ASSERT_NEXT(a_result_held, aclk, aresetn,
        fin_reg == FIN_WAIT && m_tvalid_reg && !m_tready,
        fin_reg == FIN_WAIT && m_tvalid_reg)

endmodule

`default_nettype wire

// ===== tb/tb_extended_gcd_unit_core.sv =====
`timescale 1ns / 1ps

module tb_extended_gcd_unit_core;
    import egcd_pkg::*;

    localparam int W              = 32;
    localparam int S_BITS         = pad_to_bytes(2*W);
    localparam int M_BITS         = pad_to_bytes(3*W-1);
    localparam int RANDOM_PAIRS   = 350;
    localparam int CALM_TAIL      = 30;
    localparam int LONG_HOLD      = 4000;
    localparam int DRAIN_CYCLES   = 1700;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_DIRECTED   = 23;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic [W-2:0] divisor;
        logic [W-1:0] coef_a;
        logic [W-1:0] coef_b;
    } gcd_result_t;

    // One row of the directed stimulus; the result is typed in only when known flag is set.
    typedef struct {
        int a;
        int b;
        bit known;
        int gcd;
        int ca;
        int cb;
    } gcd_case_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // operand_a, operand_b (lowest bits first)
    logic [S_BITS-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // divisor, coef_a, coef_b (lowest bits first)
    logic [M_BITS-1:0] m_tdata;

    gcd_result_t awaited_gcds[$];
    gcd_case_t   directed_cases [NUM_DIRECTED];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          quiet_cycles   = 0;
    bit          calm           = 1'b0;
    bit          long_hold_done = 1'b0;

    extended_gcd_unit_core #(
        .DATA_WIDTH(W)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock generation.
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Extended Euclid on the operand magnitudes, with coefficients kept modulo 2^W.
    function automatic gcd_result_t bezout_predict(input bit [W-1:0] a, input bit [W-1:0] b);
        bit [W-1:0] r_prev, r_cur, quo, rem;
        bit [W-1:0] s_prev, t_prev, s_cur, t_cur, s_next, t_next;
        gcd_result_t res;
        r_prev = a[W-1] ? -a : a;
        r_cur  = b[W-1] ? -b : b;
        s_prev = 1;
        t_prev = 0;
        s_cur  = 0;
        t_cur  = 1;
        while (r_cur != 0) begin
            quo    = r_prev / r_cur;
            rem    = r_prev % r_cur;
            s_next = s_prev - quo * s_cur;
            t_next = t_prev - quo * t_cur;
            s_prev = s_cur;
            t_prev = t_cur;
            s_cur  = s_next;
            t_cur  = t_next;
            r_prev = r_cur;
            r_cur  = rem;
        end
        res.divisor = r_prev[W-2:0];
        res.coef_a  = a[W-1] ? -s_prev : s_prev;
        res.coef_b  = b[W-1] ? -t_prev : t_prev;
        return res;
    endfunction

    // Gives a magnitude a random sign.
    function automatic bit [W-1:0] with_random_sign(input bit [W-1:0] mag);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // Full-range random operand; the most negative value is outside the range.
    function automatic bit [W-1:0] full_operand();
        bit [W-1:0] v;
        v = $urandom;
        if (v == {1'b1, {(W-1){1'b0}}})
            v = v + 1;
        return v;
    endfunction

    // Picks a random operand pair from a mix of shapes.
    task automatic pick_random_pair(output bit [W-1:0] a, output bit [W-1:0] b);
        int unsigned fib_lo, fib_hi, fib_tmp, steps, g;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                a = full_operand();
                b = full_operand();
            end
            3: begin
                // Shared factor, so the divisor is rarely 1.
                g = $urandom_range(1, 1000);
                a = with_random_sign(g * $urandom_range(0, 2000000));
                b = with_random_sign(g * $urandom_range(0, 2000000));
            end
            4: begin
                // Consecutive Fibonacci numbers need the most division steps.
                fib_lo = 0;
                fib_hi = 1;
                steps  = $urandom_range(1, 45);
                repeat (steps) begin
                    fib_tmp = fib_lo + fib_hi;
                    fib_lo  = fib_hi;
                    fib_hi  = fib_tmp;
                end
                a = with_random_sign(fib_hi);
                b = with_random_sign(fib_lo);
            end
            5: begin
                a = with_random_sign($urandom_range(0, 64));
                b = with_random_sign($urandom_range(0, 64));
            end
            6: begin
                // One operand zero.
                if ($urandom_range(0, 1) == 1) begin
                    a = full_operand();
                    b = 0;
                end else begin
                    a = 0;
                    b = full_operand();
                end
            end
            7: begin
                // One operand a multiple of the other.
                g = $urandom_range(1, 65535);
                a = with_random_sign(g * $urandom_range(1, 30000));
                b = with_random_sign(g);
            end
            default: begin
                a = full_operand();
                b = with_random_sign($urandom_range(1, 1000));
            end
        endcase
    endtask

    // Offers one input transaction, sometimes after a random gap, and records its expected result.
    task automatic offer_pair(input bit [W-1:0] a, input bit [W-1:0] b, input bit known,
                              input gcd_result_t typed);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        awaited_gcds.push_back(known ? typed : bezout_predict(a, b));
    endtask

    // Reset, stimulus and end of run.
    initial begin
        bit [W-1:0]  a, b;
        gcd_result_t typed;
        directed_cases = '{
            '{0, 0, 1'b1, 0, 1, 0},
            '{5, 0, 1'b1, 5, 1, 0},
            '{-5, 0, 1'b1, 5, -1, 0},
            '{2147483647, 0, 1'b1, 2147483647, 1, 0},
            '{-2147483647, 0, 1'b1, 2147483647, -1, 0},
            '{0, 7, 1'b1, 7, 0, 1},
            '{0, -7, 1'b1, 7, 0, -1},
            '{0, 2147483647, 1'b0, 0, 0, 0},
            '{1, 1, 1'b0, 0, 0, 0},
            '{-1, -1, 1'b0, 0, 0, 0},
            '{2147483647, 2147483647, 1'b0, 0, 0, 0},
            '{2147483647, -2147483647, 1'b0, 0, 0, 0},
            '{-2147483647, 1, 1'b0, 0, 0, 0},
            '{240, 46, 1'b0, 0, 0, 0},
            '{-240, 46, 1'b0, 0, 0, 0},
            '{240, -46, 1'b0, 0, 0, 0},
            '{1836311903, 1134903170, 1'b0, 0, 0, 0},
            '{-1134903170, 1836311903, 1'b0, 0, 0, 0},
            '{1073741824, 536870912, 1'b0, 0, 0, 0},
            '{2147483646, 2147483647, 1'b0, 0, 0, 0},
            '{12, 18, 1'b0, 0, 0, 0},
            '{1, 2147483647, 1'b0, 0, 0, 0},
            '{2147483647, 2, 1'b0, 0, 0, 0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases.
        foreach (directed_cases[i]) begin
            typed.divisor = (W-1)'(directed_cases[i].gcd);
            typed.coef_a  = directed_cases[i].ca;
            typed.coef_b  = directed_cases[i].cb;
            offer_pair(directed_cases[i].a, directed_cases[i].b, directed_cases[i].known, typed);
        end

        // Random pairs; the last stretch runs with no idling on either side.
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n >= RANDOM_PAIRS - CALM_TAIL)
                calm = 1'b1;
            pick_random_pair(a, b);
            offer_pair(a, b, 1'b0, typed);
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then watch for strays.
        while (awaited_gcds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("extended_gcd_unit_core test passed");
        else
            $display("extended_gcd_unit_core test failed");
        $finish;
    end

    // Result side backpressure: random bursts, one long hold-off, none at the end.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 30) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin : result_check
        gcd_result_t want;
        gcd_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            got.divisor = m_tdata[W-2:0];
            got.coef_a  = m_tdata[2*W-2:W-1];
            got.coef_b  = m_tdata[3*W-2:2*W-1];
            if (awaited_gcds.size() == 0) begin
                $error("result with none expected: divisor %0d", got.divisor);
                mismatch_count++;
            end else begin
                want = awaited_gcds.pop_front();
                if (got.divisor !== want.divisor) begin
                    $error("divisor: expected %0d, got %0d", want.divisor, got.divisor);
                    mismatch_count++;
                end
                if (got.coef_a !== want.coef_a) begin
                    $error("coef_a: expected %0d, got %0d",
                           $signed(want.coef_a), $signed(got.coef_a));
                    mismatch_count++;
                end
                if (got.coef_b !== want.coef_b) begin
                    $error("coef_b: expected %0d, got %0d",
                           $signed(want.coef_b), $signed(got.coef_b));
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("extended_gcd_unit_core test failed");
            $finish;
        end
    end

endmodule
